// File: hw/rtl/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg: shared types and constants for the window median selector
// sizes of the sorting cell chain and the link between neighboring cells
// ----------------------------------------------------------------------------
package wms_pkg;

	localparam int NUM_CELLS = 32;
	localparam int DATA_W    = 32;
	localparam int CNT_W     = $clog2(NUM_CELLS + 1);
	localparam int IDX_W     = $clog2(NUM_CELLS);

	typedef logic signed [DATA_W-1:0] sample_t;

	// what one cell shows to the cell on its right
	typedef struct packed {
		logic    valid;
		logic    gt;     // held value sorts after the incoming sample
		sample_t value;
	} cell_link_t;

endpackage

// File: hw/rtl/window_median_select.sv
// ----------------------------------------------------------------------------
// window_median_select: median of a window of signed samples
// a chain of insertion cells keeps the window sorted as samples arrive; the
// result is the element at index count/2, overflow marks dropped samples
// ----------------------------------------------------------------------------
// result: the closing sample sets pending_q, then the result is registered once the
// output is free; throughput: one sample per cycle while s_tready is high; after the
// closing sample s_tready stays low until the sorted chain is read at count/2 and cleared
// reset: arst_n clears the count, the dropped-sample and pending flags, all cell valid
// bits and the output valid; cell values, median and overflow output are undefined until written
module window_median_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] median_value
	output logic        m_tuser    // [0] overflow
);
	import wms_pkg::*;

	cell_link_t            links [NUM_CELLS];
	cell_link_t            head;
	logic [CNT_W-1:0]      count_q;
	logic                  dropped_q;
	logic                  pending_q;
	logic                  s_fire;
	logic                  room;
	logic                  ins;
	logic                  finish;
	logic [IDX_W-1:0]      mid_idx;
	logic                  m_tvalid_q;
	logic [DATA_W-1:0]     median_q;
	logic                  overflow_q;

	assign s_tready = !pending_q;
	assign s_fire   = s_tvalid && s_tready;
	assign room     = count_q < CNT_W'(NUM_CELLS);
	assign ins      = s_fire && room;
	assign finish   = pending_q && (!m_tvalid_q || m_tready);
	assign mid_idx  = count_q[IDX_W:1];

	// left end of the chain: always valid, never shifts
	assign head.valid = 1'b1;
	assign head.gt    = 1'b0;
	assign head.value = '0;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		wms_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ins    (ins),
			.clr    (finish),
			.sample (sample_t'(s_tdata)),
			.prev   ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
			.link   (links[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			dropped_q  <= 1'b0;
			pending_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (finish) begin
			count_q    <= '0;
			dropped_q  <= 1'b0;
			pending_q  <= 1'b0;
			m_tvalid_q <= 1'b1;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (s_fire) begin
				if (room) begin
					count_q <= count_q + 1'b1;
				end else begin
					dropped_q <= 1'b1;
				end
				pending_q <= s_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			median_q   <= links[mid_idx].value;
			overflow_q <= dropped_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = median_q;
	assign m_tuser  = overflow_q;

endmodule

// File: hw/rtl/wms_cell.sv
// ----------------------------------------------------------------------------
// wms_cell: one slot of the sorted insertion chain
// holds one sample; on insert it keeps its value, takes the new sample or
// takes its left neighbor's value so the chain stays in ascending order
// ----------------------------------------------------------------------------
module wms_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ins,
	input  logic                clr,
	input  wms_pkg::sample_t    sample,
	input  wms_pkg::cell_link_t prev,
	output wms_pkg::cell_link_t link
);
	import wms_pkg::*;

	logic    valid_q;
	sample_t value_q;
	logic    gt;

	// an empty slot counts as larger than any sample
	assign gt = !valid_q || (value_q > sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clr) begin
			valid_q <= 1'b0;
		end else if (ins && gt) begin
			valid_q <= valid_q | prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ins && gt) begin
			value_q <= prev.gt ? prev.value : sample;
		end
	end

	assign link.valid = valid_q;
	assign link.gt    = gt;
	assign link.value = value_q;

endmodule
